@@ hw/rtl/mvm_pkg.sv @@
// Package with the shared widths, types and helper functions of the matrix-vector core.
package mvm_pkg;

    // Storage and sample sizes.
    localparam int MAX_SIZE     = 64;
    localparam int SAMPLE_WIDTH = 16;

    // Fixed widths of the register and result fields.
    localparam int SIZE_BITS = 7;
    localparam int IDX_BITS  = 6;
    localparam int SUM_BITS  = 38;

    // Derived widths.
    localparam int ADDR_BITS = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int PROD_BITS = 2 * SAMPLE_WIDTH;
    localparam int EXT_BITS  = ((PROD_BITS > SUM_BITS) ? PROD_BITS : SUM_BITS) + 1;
    localparam int DIM_BITS  = ((SIZE_BITS > ADDR_BITS) ? SIZE_BITS : ADDR_BITS) + 1;
    localparam int COLX_BITS = (ADDR_BITS > IDX_BITS) ? ADDR_BITS : IDX_BITS;

    // Stream data widths, padded to whole bytes.
    localparam int S_DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int M_FLD_W  = IDX_BITS + SUM_BITS;
    localparam int M_DATA_W = ((M_FLD_W + 7) / 8) * 8;
    localparam int M_PAD_W  = M_DATA_W - M_FLD_W;

    // Size register after reset.
    localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(64);

    // Saturation limits of the accumulator at the extended width.
    localparam logic signed [EXT_BITS-1:0] SUM_HI =
        {{(EXT_BITS - SUM_BITS + 1){1'b0}}, {(SUM_BITS - 1){1'b1}}};
    localparam logic signed [EXT_BITS-1:0] SUM_LO =
        {{(EXT_BITS - SUM_BITS + 1){1'b1}}, {(SUM_BITS - 1){1'b0}}};

    // Kind codes on the input stream.
    typedef enum logic {
        KIND_VECTOR = 1'b0,
        KIND_MATRIX = 1'b1
    } kind_t;

    // One matrix element on its way from the counters to the multiplier.
    typedef struct packed {
        logic                           col_end;
        logic                           last_col;
        logic [ADDR_BITS-1:0]           col;
        logic signed [SAMPLE_WIDTH-1:0] sample;
    } beat_t;

    // Highest valid index for a size register value: zero reads as one, and
    // anything above the store depth reads as the store depth.
    function automatic logic [ADDR_BITS-1:0] dim_last(input logic [SIZE_BITS-1:0] size);
        logic [DIM_BITS-1:0] s;
        s = DIM_BITS'(size);
        if (size == '0)
        begin
            return '0;
        end
        else if (s > DIM_BITS'(MAX_SIZE))
        begin
            return ADDR_BITS'(MAX_SIZE - 1);
        end
        else
        begin
            return ADDR_BITS'(s - DIM_BITS'(1));
        end
    endfunction

    // Accumulator add that clamps to the signed range of the sum.
    function automatic logic signed [SUM_BITS-1:0] sat_add(
        input logic signed [SUM_BITS-1:0]  a,
        input logic signed [PROD_BITS-1:0] p
    );
        logic signed [EXT_BITS-1:0] s;
        s = EXT_BITS'(a) + EXT_BITS'(p);
        if (s > SUM_HI)
        begin
            return SUM_HI[SUM_BITS-1:0];
        end
        else if (s < SUM_LO)
        begin
            return SUM_LO[SUM_BITS-1:0];
        end
        else
        begin
            return s[SUM_BITS-1:0];
        end
    endfunction

endpackage

@@ hw/rtl/mvm_vector_ram.sv @@
// Vector store: one write port and one registered read port.
module mvm_vector_ram (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [mvm_pkg::ADDR_BITS-1:0]            wr_addr,
    input  logic signed [mvm_pkg::SAMPLE_WIDTH-1:0]  wr_data,
    input  logic                                     rd_en,
    input  logic [mvm_pkg::ADDR_BITS-1:0]            rd_addr,
    output logic signed [mvm_pkg::SAMPLE_WIDTH-1:0]  rd_data
);

    logic signed [mvm_pkg::SAMPLE_WIDTH-1:0] mem [mvm_pkg::MAX_SIZE];
    logic signed [mvm_pkg::SAMPLE_WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/mvm_ctrl.sv @@
// Size register, load/row/column counters and vector store addressing.
module mvm_ctrl (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_wr_en,
    input  logic [mvm_pkg::SIZE_BITS-1:0]            cfg_wr_data,
    input  logic                                     in_valid,
    input  logic                                     in_ready,
    input  mvm_pkg::kind_t                           in_kind,
    input  logic signed [mvm_pkg::SAMPLE_WIDTH-1:0]  in_sample,
    output logic                                     ram_wr_en,
    output logic [mvm_pkg::ADDR_BITS-1:0]            ram_wr_addr,
    output logic signed [mvm_pkg::SAMPLE_WIDTH-1:0]  ram_wr_data,
    output logic                                     ram_rd_en,
    output logic [mvm_pkg::ADDR_BITS-1:0]            ram_rd_addr,
    output logic                                     beat_valid,
    output mvm_pkg::beat_t                           beat
);

    logic [mvm_pkg::ADDR_BITS-1:0] last_reg, last_next;
    logic [mvm_pkg::ADDR_BITS-1:0] load_pos_reg, load_pos_next;
    logic [mvm_pkg::ADDR_BITS-1:0] row_pos_reg, row_pos_next;
    logic [mvm_pkg::ADDR_BITS-1:0] col_pos_reg, col_pos_next;
    logic                          xfer;
    logic                          load_xfer;
    logic                          mat_xfer;
    logic                          row_end;
    logic                          col_end;

    // Decode the accepted transaction.
    assign xfer      = in_valid && in_ready;
    assign load_xfer = xfer && (in_kind == mvm_pkg::KIND_VECTOR);
    assign mat_xfer  = xfer && (in_kind == mvm_pkg::KIND_MATRIX);
    assign row_end   = (row_pos_reg == last_reg);
    assign col_end   = (col_pos_reg == last_reg);

    // Vector loads write the store; matrix elements read it at their row.
    assign ram_wr_en   = load_xfer;
    assign ram_wr_addr = load_pos_reg;
    assign ram_wr_data = in_sample;
    assign ram_rd_en   = mat_xfer;
    assign ram_rd_addr = row_pos_reg;

    // Element handed to the multiply-accumulate path.
    assign beat_valid    = mat_xfer;
    assign beat.col_end  = row_end;
    assign beat.last_col = col_end;
    assign beat.col      = col_pos_reg;
    assign beat.sample   = in_sample;

    // Counter updates; a size write clears all positions.
    always_comb
    begin
        last_next     = last_reg;
        load_pos_next = load_pos_reg;
        row_pos_next  = row_pos_reg;
        col_pos_next  = col_pos_reg;
        if (cfg_wr_en)
        begin
            last_next     = mvm_pkg::dim_last(cfg_wr_data);
            load_pos_next = '0;
            row_pos_next  = '0;
            col_pos_next  = '0;
        end
        else if (load_xfer)
        begin
            load_pos_next = (load_pos_reg == last_reg) ? '0 : load_pos_reg + 1'b1;
        end
        else if (mat_xfer)
        begin
            row_pos_next = row_end ? '0 : row_pos_reg + 1'b1;
            if (row_end)
            begin
                col_pos_next = col_end ? '0 : col_pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg     <= mvm_pkg::dim_last(mvm_pkg::SIZE_RESET);
            load_pos_reg <= '0;
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
        end
        else
        begin
            last_reg     <= last_next;
            load_pos_reg <= load_pos_next;
            row_pos_reg  <= row_pos_next;
            col_pos_reg  <= col_pos_next;
        end
    end

    // All positions stay inside the configured dimension.
    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_pos_reg <= last_reg)
        else $error("row position beyond the dimension");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_pos_reg <= last_reg)
        else $error("column position beyond the dimension");

    a_load_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        load_pos_reg <= last_reg)
        else $error("load position beyond the dimension");

endmodule

@@ hw/rtl/mvm_mac.sv @@
// Multiply-accumulate pipeline with the result output register.
module mvm_mac (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     acc_clear,
    input  logic                                     beat_valid,
    input  mvm_pkg::beat_t                           beat,
    input  logic signed [mvm_pkg::SAMPLE_WIDTH-1:0]  vec_data,
    output logic                                     take_ok,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [mvm_pkg::M_DATA_W-1:0]             m_tdata,
    output logic                                     m_tlast
);

    // Stage 1: element waiting for its vector entry from the store.
    logic                                   s1_valid_reg, s1_valid_next;
    mvm_pkg::beat_t                         s1_beat_reg;
    // Stage 2: registered product.
    logic                                   s2_valid_reg, s2_valid_next;
    logic signed [mvm_pkg::PROD_BITS-1:0]   s2_prod_reg;
    logic                                   s2_end_reg;
    logic                                   s2_last_reg;
    logic [mvm_pkg::ADDR_BITS-1:0]          s2_col_reg;
    // Accumulator and output register.
    logic signed [mvm_pkg::SUM_BITS-1:0]    acc_reg, acc_next;
    logic                                   out_valid_reg, out_valid_next;
    logic signed [mvm_pkg::SUM_BITS-1:0]    out_sum_reg;
    logic [mvm_pkg::IDX_BITS-1:0]           out_col_reg;
    logic                                   out_last_reg;

    logic                                   out_free;
    logic                                   s2_go;
    logic                                   s2_free;
    logic                                   s1_go;
    logic signed [mvm_pkg::PROD_BITS-1:0]   prod;
    logic signed [mvm_pkg::SUM_BITS-1:0]    sum;
    logic [mvm_pkg::COLX_BITS-1:0]          col_wide;

    // Flow control: only a column end needs a free output register.
    assign out_free = !out_valid_reg || m_tready;
    assign s2_go    = s2_valid_reg && (!s2_end_reg || out_free);
    assign s2_free  = !s2_valid_reg || s2_go;
    assign s1_go    = s1_valid_reg && s2_free;
    assign take_ok  = !s1_valid_reg || s1_go;

    // Product of the element and its vector entry.
    assign prod = mvm_pkg::PROD_BITS'(s1_beat_reg.sample) * mvm_pkg::PROD_BITS'(vec_data);

    // Saturating accumulate of the stage 2 product.
    assign sum      = mvm_pkg::sat_add(acc_reg, s2_prod_reg);
    assign col_wide = mvm_pkg::COLX_BITS'(s2_col_reg);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take_ok)
        begin
            s1_valid_next = beat_valid;
        end
        s2_valid_next = s2_valid_reg;
        if (s2_free)
        begin
            s2_valid_next = s1_valid_reg;
        end
        acc_next = acc_reg;
        if (acc_clear)
        begin
            acc_next = '0;
        end
        else if (s2_go)
        begin
            acc_next = s2_end_reg ? '0 : sum;
        end
        out_valid_next = out_valid_reg;
        if (s2_go && s2_end_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take_ok && beat_valid)
        begin
            s1_beat_reg <= beat;
        end
        if (s1_go)
        begin
            s2_prod_reg <= prod;
            s2_end_reg  <= s1_beat_reg.col_end;
            s2_last_reg <= s1_beat_reg.last_col;
            s2_col_reg  <= s1_beat_reg.col;
        end
        if (s2_go && s2_end_reg)
        begin
            out_sum_reg  <= sum;
            out_col_reg  <= col_wide[mvm_pkg::IDX_BITS-1:0];
            out_last_reg <= s2_last_reg;
        end
    end

    // Result stream; fields from the lowest bit up.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{mvm_pkg::M_PAD_W{1'b0}}, out_sum_reg, out_col_reg};
    assign m_tlast  = out_last_reg;

    // A column end always produces a result in the next cycle.
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_go && s2_end_reg) |=> out_valid_reg)
        else $error("column end did not reach the output register");

    // The accumulator starts every column from zero.
    a_acc_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_go && s2_end_reg) |=> (acc_reg == '0))
        else $error("accumulator not cleared after a column end");

    // A waiting result is never overwritten by the next column end.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready && s2_valid_reg && s2_end_reg) |=> s2_valid_reg)
        else $error("column end dropped while the result waits");

endmodule

@@ hw/rtl/matrix_vector_multiply_core.sv @@
// A column end passes stage 1, the stage 2 product and the output register on its way to m_tvalid.
// One element per cycle unless stalled, set by one multiply-accumulate and one store read.
// The input keeps taking elements while a finished result waits, until stage 1 fills.
// Reset clears the counters and the accumulator and sets the size register to 64.
// The vector store is not cleared; a size write clears the counters and accumulator only.
// Top level of the streamed matrix-vector product core.
module matrix_vector_multiply_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // Size register write port.
    input  logic                            cfg_wr_en,
    input  logic [mvm_pkg::SIZE_BITS-1:0]   cfg_wr_data,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mvm_pkg::S_DATA_W-1:0]    s_tdata,   // value_in
    input  logic                            s_tuser,   // kind
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mvm_pkg::M_DATA_W-1:0]    m_tdata,   // column_index, dot_product
    output logic                            m_tlast    // last_column
);

    logic                                     take_ok;
    logic                                     ram_wr_en;
    logic [mvm_pkg::ADDR_BITS-1:0]            ram_wr_addr;
    logic signed [mvm_pkg::SAMPLE_WIDTH-1:0]  ram_wr_data;
    logic                                     ram_rd_en;
    logic [mvm_pkg::ADDR_BITS-1:0]            ram_rd_addr;
    logic signed [mvm_pkg::SAMPLE_WIDTH-1:0]  ram_rd_data;
    logic                                     beat_valid;
    mvm_pkg::beat_t                           beat;
    mvm_pkg::kind_t                           in_kind;
    logic signed [mvm_pkg::SAMPLE_WIDTH-1:0]  in_sample;

    assign s_tready  = take_ok;
    assign in_kind   = mvm_pkg::kind_t'(s_tuser);
    assign in_sample = s_tdata[mvm_pkg::SAMPLE_WIDTH-1:0];

    // Counters and store addressing.
    mvm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (take_ok),
        .in_kind     (in_kind),
        .in_sample   (in_sample),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .beat_valid  (beat_valid),
        .beat        (beat)
    );

    // Vector store.
    mvm_vector_ram u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Multiply-accumulate and result register.
    mvm_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .acc_clear  (cfg_wr_en),
        .beat_valid (beat_valid),
        .beat       (beat),
        .vec_data   (ram_rd_data),
        .take_ok    (take_ok),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the streamed matrix-vector product core.
`timescale 1ns / 100ps

module tb;

    // One finished column as the core should report it.
    typedef struct {
        logic [mvm_pkg::IDX_BITS-1:0]        col;
        logic signed [mvm_pkg::SUM_BITS-1:0] sum;
        logic                                last;
    } column_result_t;

    // Tracks the vector store, the counters and the accumulator, and holds
    // the column sums that are still to come out of the core.
    class column_sum_tracker;
        logic signed [mvm_pkg::SAMPLE_WIDTH-1:0] vec_mem [mvm_pkg::MAX_SIZE];
        bit                             written [mvm_pkg::MAX_SIZE];
        int unsigned                    dim_n;
        int unsigned                    load_pos;
        int unsigned                    row_pos;
        int unsigned                    col_pos;
        longint                         acc;
        column_result_t                 pending_columns [$];
        int                             errors;

        function new();
            foreach (written[i])
            begin
                written[i] = 1'b0;
                vec_mem[i] = '0;
            end
            dim_n    = mvm_pkg::MAX_SIZE;
            load_pos = 0;
            row_pos  = 0;
            col_pos  = 0;
            acc      = 0;
            errors   = 0;
        endfunction

        // A size write clamps the dimension and clears all counters.
        function void resize(logic [mvm_pkg::SIZE_BITS-1:0] value);
            if (value == '0)
            begin
                dim_n = 1;
            end
            else if (value > mvm_pkg::MAX_SIZE)
            begin
                dim_n = mvm_pkg::MAX_SIZE;
            end
            else
            begin
                dim_n = value;
            end
            load_pos = 0;
            row_pos  = 0;
            col_pos  = 0;
            acc      = 0;
        endfunction

        // True when the next matrix element reads a vector entry that holds data.
        function bit row_ready();
            int unsigned r;
            r = (row_pos >= dim_n) ? 0 : row_pos;
            return written[r];
        endfunction

        // Applies one accepted input transaction.
        function void take_element(mvm_pkg::kind_t k,
                                   logic signed [mvm_pkg::SAMPLE_WIDTH-1:0] x);
            column_result_t res;
            longint         s;
            longint         sum_max;
            sum_max = (longint'(1) <<< (mvm_pkg::SUM_BITS - 1)) - 1;
            if (k == mvm_pkg::KIND_VECTOR)
            begin
                if (load_pos >= dim_n)
                begin
                    load_pos = 0;
                end
                vec_mem[load_pos] = x;
                written[load_pos] = 1'b1;
                load_pos++;
                if (load_pos >= dim_n)
                begin
                    load_pos = 0;
                end
                return;
            end
            if (row_pos >= dim_n)
            begin
                row_pos = 0;
            end
            if (col_pos >= dim_n)
            begin
                col_pos = 0;
            end
            s = acc + longint'(x) * longint'(vec_mem[row_pos]);
            if (s > sum_max)
            begin
                s = sum_max;
            end
            if (s < -sum_max - 1)
            begin
                s = -sum_max - 1;
            end
            acc = s;
            row_pos++;
            if (row_pos >= dim_n)
            begin
                res.col  = col_pos[mvm_pkg::IDX_BITS-1:0];
                res.sum  = acc[mvm_pkg::SUM_BITS-1:0];
                res.last = (col_pos == dim_n - 1);
                pending_columns.push_back(res);
                acc     = 0;
                row_pos = 0;
                col_pos++;
                if (col_pos >= dim_n)
                begin
                    col_pos = 0;
                end
            end
        endfunction

        // Compares one result transaction with the oldest column sum.
        function void match_column(logic [mvm_pkg::M_DATA_W-1:0] data, logic last);
            column_result_t exp_res;
            logic [mvm_pkg::IDX_BITS-1:0]  got_col;
            logic [mvm_pkg::SUM_BITS-1:0]  got_sum;
            logic [mvm_pkg::M_PAD_W-1:0]   got_pad;
            got_col = data[mvm_pkg::IDX_BITS-1:0];
            got_sum = data[mvm_pkg::IDX_BITS +: mvm_pkg::SUM_BITS];
            got_pad = data[mvm_pkg::M_DATA_W-1:mvm_pkg::M_FLD_W];
            if (pending_columns.size() == 0)
            begin
                $display("%0t: result with none pending, actual tdata %h tlast %b",
                         $time, data, last);
                errors++;
                return;
            end
            exp_res = pending_columns.pop_front();
            if (got_col !== exp_res.col)
            begin
                $display("%0t: column_index expected %0d actual %0d",
                         $time, exp_res.col, got_col);
                errors++;
            end
            if (got_sum !== exp_res.sum)
            begin
                $display("%0t: dot_product expected %h actual %h",
                         $time, exp_res.sum, got_sum);
                errors++;
            end
            if (last !== exp_res.last)
            begin
                $display("%0t: last_column expected %b actual %b",
                         $time, exp_res.last, last);
                errors++;
            end
            if (got_pad !== '0)
            begin
                $display("%0t: tdata padding expected %h actual %h",
                         $time, {mvm_pkg::M_PAD_W{1'b0}}, got_pad);
                errors++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [mvm_pkg::SIZE_BITS-1:0]   cfg_wr_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [mvm_pkg::S_DATA_W-1:0]    s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [mvm_pkg::M_DATA_W-1:0]    m_tdata;
    logic                            m_tlast;

    column_sum_tracker board = new();
    int                accepted_items = 0;
    bit                calm = 1'b0;

    matrix_vector_multiply_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Hard limit on the run time.
    initial
    begin
        #1000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Sample values biased toward the extremes of the field.
    function automatic logic [mvm_pkg::SAMPLE_WIDTH-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(mvm_pkg::SAMPLE_WIDTH-1){1'b0}}};
            1: return {1'b0, {(mvm_pkg::SAMPLE_WIDTH-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return mvm_pkg::SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    // Offers one input transaction and waits for it to be taken. Valid stays
    // high on return unless an idle burst follows.
    task automatic push_item(mvm_pkg::kind_t k, logic [mvm_pkg::SAMPLE_WIDTH-1:0] value);
        s_tvalid = 1'b1;
        s_tuser  = k;
        s_tdata  = mvm_pkg::S_DATA_W'(value);
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        board.take_element(k, value);
        accepted_items++;
        @(negedge clk);
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            s_tvalid = 1'b0;
            s_tdata  = mvm_pkg::S_DATA_W'($urandom);
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
    endtask

    // Matrix element, or a vector load where its row was never loaded.
    task automatic push_matrix(logic [mvm_pkg::SAMPLE_WIDTH-1:0] value);
        if (board.row_ready())
        begin
            push_item(mvm_pkg::KIND_MATRIX, value);
        end
        else
        begin
            push_item(mvm_pkg::KIND_VECTOR, value);
        end
    endtask

    // Stops the sender and waits until every column sum has come out.
    task automatic drain();
        s_tvalid = 1'b0;
        while (board.pending_columns.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Writes the size register once the core is idle.
    task automatic write_size(logic [mvm_pkg::SIZE_BITS-1:0] value);
        drain();
        repeat (8) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        cfg_wr_data = mvm_pkg::SIZE_BITS'($urandom);
        board.resize(value);
    endtask

    // Result side: ready drops in short random bursts.
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else if (!calm && rst_n && $urandom_range(0, 7) == 0)
            begin
                m_tready   = 1'b0;
                stall_left = $urandom_range(1, 5) - 1;
            end
            else
            begin
                m_tready = rst_n;
            end
        end
    end

    // Check every result transaction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            board.match_column(m_tdata, m_tlast);
        end
    end

    // Main stimulus.
    initial
    begin
        int unsigned n;
        int unsigned cols;
        int          goal;
        int          style;
        int          r;
        logic [mvm_pkg::SIZE_BITS-1:0] sz;

        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = mvm_pkg::KIND_VECTOR;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset size: full vector and one column at the most negative value,
        // which gives the largest possible sum.
        for (int i = 0; i < mvm_pkg::MAX_SIZE; i++)
        begin
            push_item(mvm_pkg::KIND_VECTOR, 16'h8000);
        end
        for (int i = 0; i < mvm_pkg::MAX_SIZE; i++)
        begin
            push_item(mvm_pkg::KIND_MATRIX, 16'h8000);
        end

        // Size above the store depth: the most negative sum.
        write_size(7'd127);
        for (int i = 0; i < mvm_pkg::MAX_SIZE; i++)
        begin
            push_item(mvm_pkg::KIND_MATRIX, 16'h7fff);
        end

        // Size one: every element ends a column and the product.
        write_size(7'd1);
        push_item(mvm_pkg::KIND_VECTOR, 16'h7fff);
        push_item(mvm_pkg::KIND_MATRIX, 16'h8000);
        push_item(mvm_pkg::KIND_VECTOR, 16'h8000);
        push_item(mvm_pkg::KIND_MATRIX, 16'h8000);

        // Size zero reads as one.
        write_size(7'd0);
        push_item(mvm_pkg::KIND_VECTOR, 16'hffff);
        push_item(mvm_pkg::KIND_MATRIX, 16'h0001);
        push_item(mvm_pkg::KIND_MATRIX, 16'hffff);

        // Size two: vector overrun, column wrap and mixed kinds.
        write_size(7'd2);
        push_item(mvm_pkg::KIND_VECTOR, 16'h1234);
        push_item(mvm_pkg::KIND_VECTOR, 16'h8000);
        push_item(mvm_pkg::KIND_VECTOR, 16'h7fff);
        push_item(mvm_pkg::KIND_MATRIX, 16'h4000);
        push_item(mvm_pkg::KIND_MATRIX, 16'hc000);
        push_item(mvm_pkg::KIND_MATRIX, 16'h0000);
        push_item(mvm_pkg::KIND_VECTOR, 16'h0003);
        push_item(mvm_pkg::KIND_MATRIX, 16'h7fff);
        push_item(mvm_pkg::KIND_MATRIX, 16'h8000);
        push_item(mvm_pkg::KIND_MATRIX, 16'h0001);

        // Random phases, mostly well-formed products at small sizes.
        goal = 1050;
        while (accepted_items < goal)
        begin
            calm = (accepted_items > goal - 150);
            r = $urandom_range(0, 19);
            case (r)
                0: sz = 7'd0;
                1: sz = 7'd127;
                2: sz = 7'd64;
                3: sz = mvm_pkg::SIZE_BITS'($urandom_range(9, 63));
                default: sz = mvm_pkg::SIZE_BITS'($urandom_range(1, 8));
            endcase
            write_size(sz);
            n = board.dim_n;
            style = $urandom_range(0, 5);
            if (style == 0)
            begin
                // Noise: kinds at random.
                repeat ($urandom_range(n, 3 * n))
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        push_item(mvm_pkg::KIND_VECTOR, pick_sample());
                    end
                    else
                    begin
                        push_matrix(pick_sample());
                    end
                end
            end
            else
            begin
                // Vector, then whole columns with a few stray loads; some
                // phases stop part way through a column.
                for (int i = 0; i < n; i++)
                begin
                    push_item(mvm_pkg::KIND_VECTOR, pick_sample());
                end
                cols = (n <= 8) ? $urandom_range(1, n + 1) : $urandom_range(1, 2);
                for (int i = 0; i < cols * n; i++)
                begin
                    if (style == 1 && i > 0 && $urandom_range(0, 3 * n) == 0)
                    begin
                        break;
                    end
                    if ($urandom_range(0, 29) == 0)
                    begin
                        push_item(mvm_pkg::KIND_VECTOR, pick_sample());
                    end
                    push_matrix(pick_sample());
                end
            end
        end

        // Wait for the last results, then give the verdict.
        drain();
        repeat (20) @(negedge clk);
        if (board.errors == 0 && board.pending_columns.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
